FILE: design/mp2d_pkg.sv
// Package for the padded 2-D max pooling block: register map, reset values,
// field widths and the sequencer state type. No dependencies.
package mp2d_pkg;

   localparam int DEF_MAX_COLS    = 256;
   localparam int DEF_MAX_POOL    = 8;
   localparam int DEF_SAMPLE_BITS = 16;

   localparam int HW  = 12;  // plane row position width
   localparam int CW  = 9;   // plane column position width
   localparam int PW  = 5;   // saturated pool size width
   localparam int OHW = 13;  // output row count width
   localparam int OWW = 9;   // output column count width
   localparam int ORW = 12;  // out_row width
   localparam int OCW = 8;   // out_col width
   localparam int DVW = 13;  // divider dividend width
   localparam int ROW_CAP = 4096;
   localparam int COL_CAP = 256;

   typedef enum logic [2:0] {
      REG_PLANE_ROWS  = 3'd0,
      REG_PLANE_COLS  = 3'd1,
      REG_POOL_ROWS   = 3'd2,
      REG_POOL_COLS   = 3'd3,
      REG_STEP_ROWS   = 3'd4,
      REG_STEP_COLS   = 3'd5,
      REG_BORDER_ROWS = 3'd6,
      REG_BORDER_COLS = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      PREP_OUT_ROWS = 2'd0,
      PREP_OUT_COLS = 2'd1,
      PREP_ROW_LO   = 2'd2,
      PREP_COL_LO   = 2'd3
   } prep_index_type;

   localparam logic [11:0] RST_PLANE_ROWS = 12'd16;
   localparam logic [8:0]  RST_PLANE_COLS = 9'd16;
   localparam logic [3:0]  RST_POOL       = 4'd2;
   localparam logic [3:0]  RST_STEP       = 4'd2;
   localparam logic [2:0]  RST_BORDER     = 3'd0;

   typedef enum logic [2:0] {
      ST_PREP,
      ST_IDLE,
      ST_RANGE,
      ST_WIN,
      ST_SCAN,
      ST_FIN,
      ST_EMIT,
      ST_ADV
   } state_type;

endpackage

FILE: design/max_pool_2d_padded_top.sv
// Padded 2-D max pooling, top level: line store, shared divider, window sequencer.
// Depends on mp2d_pkg.
//
// Usage: samples of a plane enter row-major on req_ (one per transaction).
// Each sample is written into the line store; every window whose last real
// sample it is gets read back one stored sample per cycle through a single
// compare unit, and its maximum leaves on rsp_ with out_row/out_col.
// rsp_tlast marks the last result of a sample, rsp_tuser the plane's last.
// An item passes the range and advance states and, per window, the setup,
// scan, finish and emit states and the wait for rsp_tready; the single read
// port of the line store paces the scan. req_tready is low until the item is
// fully done. A stalled receiver holds the result and the whole block.
// After reset and after every register write the block runs a setup pass
// through the 13-step shared divider (output counts, last-row and last-column
// start indices) with req_tready low; the write also restarts the plane at
// row 0, column 0. The line store is not cleared.
// Registers sit on the csr_ port at byte address 4*index, pready always high.
module max_pool_2d_padded_top
   import mp2d_pkg::*;
#(
   parameter int MAX_COLS    = DEF_MAX_COLS,
   parameter int MAX_POOL    = DEF_MAX_POOL,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   localparam int REQ_W = ((SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((SAMPLE_BITS + ORW + OCW + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // sample
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // max_value, out_row, out_col
   output logic             rsp_tlast,   // run_last
   output logic             rsp_tuser,   // plane_done
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [4:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int SW    = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
   localparam int DEPTH = MAX_POOL * MAX_COLS;
   localparam int AW    = $clog2(DEPTH);

   state_type state_ff, state_in;

   logic [11:0] plane_rows_ff;
   logic [8:0]  plane_cols_ff;
   logic [3:0]  pool_rows_ff, pool_cols_ff, step_rows_ff, step_cols_ff;
   logic [2:0]  border_rows_ff, border_cols_ff;

   logic        cfg_wr;
   reg_index_type cfg_idx;

   logic [HW-1:0] h;
   logic [CW-1:0] w;
   logic [PW-1:0] pr, pc;
   logic [2:0]    br, bc;
   logic [3:0]    sr, sc;

   // shared divider and setup pass
   logic [1:0]     prep_idx_ff, prep_idx_in;
   logic           div_busy_ff, div_busy_in;
   logic [3:0]     div_cnt_ff, div_cnt_in;
   logic [DVW-1:0] dq_ff, dq_in;
   logic [3:0]     dr_ff, dr_in;
   logic [3:0]     dsr;
   logic [4:0]     trial;
   logic           ge;
   logic [DVW-1:0] dvd;
   logic [12:0]    padded_r;
   logic [9:0]     padded_c;
   logic           empty_r, empty_c;
   logic signed [13:0] lo_r;
   logic signed [10:0] lo_c;
   logic [DVW:0]   q_plus;

   logic [OHW-1:0] oh_ff, oh_in;
   logic [OWW-1:0] ow_ff, ow_in;
   logic [OHW-1:0] ra_lo_ff, ra_lo_in;
   logic [9:0]     ca_lo_ff, ca_lo_in;

   // plane position and finishing trackers
   logic [HW-1:0] r_ff, r_in;
   logic [CW-1:0] c_ff, c_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic signed [13:0] rt_ff, rt_in, rt_init;
   logic [3:0]    rm_ff, rm_in, cm_ff, cm_in;
   logic [OHW-1:0] rq_ff, rq_in;
   logic signed [10:0] ct_ff, ct_in, ct_init;
   logic [9:0]    cq_ff, cq_in;

   // window loop
   logic [ORW-1:0] ra_ff, ra_in, rz_ff, rz_in, orow_ff, orow_in;
   logic [OCW-1:0] ca_ff, ca_in, cz_ff, cz_in, ocol_ff, ocol_in;
   logic           row_hit, col_hit;
   logic [OHW-1:0] ra_c, rz_c;
   logic [9:0]     ca_c, cz_c;
   logic [HW-1:0]  y_ff, y_in, y_end_ff, y_end_in;
   logic [CW-1:0]  x_ff, x_in, x0_ff, x0_in, x_end_ff, x_end_in;
   logic [15:0]    prod_r;
   logic [11:0]    prod_c;
   logic signed [17:0] r0s, r1s;
   logic signed [13:0] c0s, c1s;
   logic [SAMPLE_BITS-1:0] best_ff, best_in;

   // line store
   logic [SAMPLE_BITS-1:0] mem [DEPTH];
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic           rd_vld_ff;
   logic           rd_en;
   logic [AW-1:0]  rd_addr, wr_addr;
   logic [SW-1:0]  row_dist, rd_slot;
   logic [SW:0]    slot_wrap;
   logic           req_acc, rsp_acc;

   assign cfg_wr  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg_idx = reg_index_type'(csr_paddr[4:2]);
   assign req_acc = req_tvalid & req_tready;
   assign rsp_acc = rsp_tvalid & rsp_tready;

   // saturated configuration
   always_comb begin
      h  = (plane_rows_ff == '0) ? HW'(1) : plane_rows_ff;
      w  = (plane_cols_ff == '0) ? CW'(1) :
           ((32'(plane_cols_ff) > MAX_COLS) ? CW'(MAX_COLS) : plane_cols_ff);
      pr = (pool_rows_ff == '0) ? PW'(1) :
           ((32'(pool_rows_ff) > MAX_POOL) ? PW'(MAX_POOL) : PW'(pool_rows_ff));
      pc = (pool_cols_ff == '0) ? PW'(1) :
           ((32'(pool_cols_ff) > MAX_POOL) ? PW'(MAX_POOL) : PW'(pool_cols_ff));
      br = (PW'(border_rows_ff) > (pr >> 1)) ? 3'(pr >> 1) : border_rows_ff;
      bc = (PW'(border_cols_ff) > (pc >> 1)) ? 3'(pc >> 1) : border_cols_ff;
      sr = (step_rows_ff == '0) ? 4'd1 : step_rows_ff;
      sc = (step_cols_ff == '0) ? 4'd1 : step_cols_ff;
   end

   // setup pass dividends
   always_comb begin
      padded_r = 13'(h) + 13'({br, 1'b0});
      padded_c = 10'(w) + 10'({bc, 1'b0});
      empty_r  = padded_r < 13'(pr);
      empty_c  = padded_c < 10'(pc);
      lo_r     = $signed(14'(h)) + $signed(14'(br)) - $signed(14'(pr));
      lo_c     = $signed(11'(w)) + $signed(11'(bc)) - $signed(11'(pc));
      rt_init  = $signed(14'(br)) + 14'sd1 - $signed(14'(pr));
      ct_init  = $signed(11'(bc)) + 11'sd1 - $signed(11'(pc));
      dsr      = prep_idx_ff[0] ? sc : sr;
      dvd      = '0;
      case (prep_index_type'(prep_idx_ff))
         PREP_OUT_ROWS: dvd = empty_r ? '0 : DVW'(padded_r - 13'(pr));
         PREP_OUT_COLS: dvd = empty_c ? '0 : DVW'(padded_c - 10'(pc));
         PREP_ROW_LO:   dvd = (lo_r <= 0) ? '0 : DVW'(lo_r + $signed(14'(sr)) - 14'sd1);
         PREP_COL_LO:   dvd = (lo_c <= 0) ? '0 : DVW'(lo_c + $signed(11'(sc)) - 11'sd1);
         default:       dvd = '0;
      endcase
      trial = {dr_ff, dq_ff[DVW-1]};
      ge    = trial >= {1'b0, dsr};
   end

   // finishing ranges for the current position
   always_comb begin
      if (r_ff != h - HW'(1)) begin
         row_hit = !rt_ff[13] && (rm_ff == '0) && (rq_ff < oh_ff);
         ra_c    = rq_ff;
         rz_c    = rq_ff;
      end else begin
         row_hit = (oh_ff != '0) && (ra_lo_ff <= oh_ff - OHW'(1));
         ra_c    = ra_lo_ff;
         rz_c    = oh_ff - OHW'(1);
      end
      if (c_ff != w - CW'(1)) begin
         col_hit = !ct_ff[10] && (cm_ff == '0) && (cq_ff < 10'(ow_ff));
         ca_c    = cq_ff;
         cz_c    = cq_ff;
      end else begin
         col_hit = (ow_ff != '0) && (ca_lo_ff <= 10'(ow_ff - OWW'(1)));
         ca_c    = ca_lo_ff;
         cz_c    = 10'(ow_ff - OWW'(1));
      end
   end

   // window bounds
   always_comb begin
      prod_r = 16'(orow_ff) * 16'(sr);
      prod_c = 12'(ocol_ff) * 12'(sc);
      r0s    = $signed(18'(prod_r)) - $signed(18'(br));
      r1s    = r0s + $signed(18'(pr)) - 18'sd1;
      c0s    = $signed(14'(prod_c)) - $signed(14'(bc));
      c1s    = c0s + $signed(14'(pc)) - 14'sd1;
   end

   // line store addressing
   always_comb begin
      row_dist  = SW'(r_ff - y_ff);
      slot_wrap = {1'b0, slot_ff} + (SW+1)'(MAX_POOL) - {1'b0, row_dist};
      rd_slot   = (slot_ff >= row_dist) ? (slot_ff - row_dist) : SW'(slot_wrap);
      rd_addr   = AW'(AW'(rd_slot) * AW'(MAX_COLS)) + AW'(x_ff);
      wr_addr   = AW'(AW'(slot_ff) * AW'(MAX_COLS)) + AW'(c_ff);
      rd_en     = (state_ff == ST_SCAN);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_PREP:  if (div_busy_ff && div_cnt_ff == 4'(DVW - 1) &&
                       prep_idx_ff == PREP_COL_LO) state_in = ST_IDLE;
         ST_IDLE:  if (req_acc) state_in = ST_RANGE;
         ST_RANGE: state_in = (row_hit && col_hit && ra_c <= rz_c && ca_c <= cz_c) ?
                              ST_WIN : ST_ADV;
         ST_WIN:   state_in = ST_SCAN;
         ST_SCAN:  if (y_ff == y_end_ff && x_ff == x_end_ff) state_in = ST_FIN;
         ST_FIN:   state_in = ST_EMIT;
         ST_EMIT:  if (rsp_acc) state_in = (orow_ff == rz_ff && ocol_ff == cz_ff) ?
                                           ST_ADV : ST_WIN;
         ST_ADV:   state_in = ST_IDLE;
         default:  state_in = ST_PREP;
      endcase
      if (cfg_wr) state_in = ST_PREP;
   end

   // outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_EMIT);
      rsp_tdata  = RSP_W'({ocol_ff, orow_ff, best_ff});
      rsp_tlast  = (orow_ff == rz_ff) && (ocol_ff == cz_ff);
      rsp_tuser  = (OHW'(orow_ff) == oh_ff - OHW'(1)) &&
                   (OWW'(ocol_ff) == ow_ff - OWW'(1));
      csr_pready = 1'b1;
      csr_prdata = '0;
      unique case (cfg_idx)
         REG_PLANE_ROWS:  csr_prdata = 32'(plane_rows_ff);
         REG_PLANE_COLS:  csr_prdata = 32'(plane_cols_ff);
         REG_POOL_ROWS:   csr_prdata = 32'(pool_rows_ff);
         REG_POOL_COLS:   csr_prdata = 32'(pool_cols_ff);
         REG_STEP_ROWS:   csr_prdata = 32'(step_rows_ff);
         REG_STEP_COLS:   csr_prdata = 32'(step_cols_ff);
         REG_BORDER_ROWS: csr_prdata = 32'(border_rows_ff);
         REG_BORDER_COLS: csr_prdata = 32'(border_cols_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // datapath next values
   always_comb begin
      prep_idx_in = prep_idx_ff;
      div_busy_in = div_busy_ff;
      div_cnt_in  = div_cnt_ff;
      dq_in = dq_ff;
      dr_in = dr_ff;
      oh_in = oh_ff;
      ow_in = ow_ff;
      ra_lo_in = ra_lo_ff;
      ca_lo_in = ca_lo_ff;
      r_in = r_ff;  c_in = c_ff;  slot_in = slot_ff;
      rt_in = rt_ff; rm_in = rm_ff; rq_in = rq_ff;
      ct_in = ct_ff; cm_in = cm_ff; cq_in = cq_ff;
      ra_in = ra_ff; rz_in = rz_ff; ca_in = ca_ff; cz_in = cz_ff;
      orow_in = orow_ff; ocol_in = ocol_ff;
      y_in = y_ff; y_end_in = y_end_ff;
      x_in = x_ff; x0_in = x0_ff; x_end_in = x_end_ff;
      best_in = best_ff;
      q_plus  = '0;

      if (rd_vld_ff && $signed(rd_data_ff) > $signed(best_ff)) best_in = rd_data_ff;

      case (state_ff)
         ST_PREP: begin
            if (!div_busy_ff) begin
               dq_in = dvd;
               dr_in = '0;
               div_cnt_in  = '0;
               div_busy_in = 1'b1;
            end else begin
               dr_in = ge ? 4'(trial - {1'b0, dsr}) : trial[3:0];
               dq_in = {dq_ff[DVW-2:0], ge};
               div_cnt_in = div_cnt_ff + 4'd1;
               if (div_cnt_ff == 4'(DVW - 1)) begin
                  div_busy_in = 1'b0;
                  prep_idx_in = prep_idx_ff + 2'd1;
                  q_plus = {1'b0, dq_in} + (DVW+1)'(1);
                  case (prep_index_type'(prep_idx_ff))
                     PREP_OUT_ROWS: oh_in = empty_r ? '0 :
                        ((q_plus > (DVW+1)'(ROW_CAP)) ? OHW'(ROW_CAP) : OHW'(q_plus));
                     PREP_OUT_COLS: ow_in = empty_c ? '0 :
                        ((q_plus > (DVW+1)'(COL_CAP)) ? OWW'(COL_CAP) : OWW'(q_plus));
                     PREP_ROW_LO:   ra_lo_in = dq_in;
                     PREP_COL_LO: begin
                        ca_lo_in = 10'(dq_in);
                        rt_in = rt_init; rm_in = '0; rq_in = '0;
                        ct_in = ct_init; cm_in = '0; cq_in = '0;
                     end
                     default: ;
                  endcase
               end
            end
         end
         ST_RANGE: begin
            ra_in   = ORW'(ra_c);
            rz_in   = ORW'(rz_c);
            ca_in   = OCW'(ca_c);
            cz_in   = OCW'(cz_c);
            orow_in = ORW'(ra_c);
            ocol_in = OCW'(ca_c);
         end
         ST_WIN: begin
            y_in     = (r0s < 0) ? '0 : HW'(r0s);
            y_end_in = (r1s > $signed(18'(h - HW'(1)))) ? (h - HW'(1)) : HW'(r1s);
            x_in     = (c0s < 0) ? '0 : CW'(c0s);
            x0_in    = (c0s < 0) ? '0 : CW'(c0s);
            x_end_in = (c1s > $signed(14'(w - CW'(1)))) ? (w - CW'(1)) : CW'(c1s);
            best_in  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         end
         ST_SCAN: begin
            if (x_ff == x_end_ff) begin
               x_in = x0_ff;
               if (y_ff != y_end_ff) y_in = y_ff + HW'(1);
            end else begin
               x_in = x_ff + CW'(1);
            end
         end
         ST_EMIT: begin
            if (rsp_acc) begin
               if (ocol_ff == cz_ff) begin
                  ocol_in = ca_ff;
                  orow_in = orow_ff + ORW'(1);
               end else begin
                  ocol_in = ocol_ff + OCW'(1);
               end
            end
         end
         ST_ADV: begin
            if (c_ff == w - CW'(1)) begin
               c_in = '0;
               ct_in = ct_init; cm_in = '0; cq_in = '0;
               if (r_ff == h - HW'(1)) begin
                  r_in = '0;
                  slot_in = '0;
                  rt_in = rt_init; rm_in = '0; rq_in = '0;
               end else begin
                  r_in = r_ff + HW'(1);
                  slot_in = (32'(slot_ff) == MAX_POOL - 1) ? '0 : slot_ff + SW'(1);
                  rt_in = rt_ff + 14'sd1;
                  if (!rt_ff[13]) begin
                     if (rm_ff == sr - 4'd1) begin
                        rm_in = '0;
                        rq_in = rq_ff + OHW'(1);
                     end else begin
                        rm_in = rm_ff + 4'd1;
                     end
                  end
               end
            end else begin
               c_in = c_ff + CW'(1);
               ct_in = ct_ff + 11'sd1;
               if (!ct_ff[10]) begin
                  if (cm_ff == sc - 4'd1) begin
                     cm_in = '0;
                     cq_in = cq_ff + 10'd1;
                  end else begin
                     cm_in = cm_ff + 4'd1;
                  end
               end
            end
         end
         default: ;
      endcase

      if (cfg_wr) begin
         prep_idx_in = '0;
         div_busy_in = 1'b0;
         r_in = '0;
         c_in = '0;
         slot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_PREP;
         plane_rows_ff  <= RST_PLANE_ROWS;
         plane_cols_ff  <= RST_PLANE_COLS;
         pool_rows_ff   <= RST_POOL;
         pool_cols_ff   <= RST_POOL;
         step_rows_ff   <= RST_STEP;
         step_cols_ff   <= RST_STEP;
         border_rows_ff <= RST_BORDER;
         border_cols_ff <= RST_BORDER;
         prep_idx_ff    <= '0;
         div_busy_ff    <= 1'b0;
         r_ff           <= '0;
         c_ff           <= '0;
         slot_ff        <= '0;
         rd_vld_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         prep_idx_ff <= prep_idx_in;
         div_busy_ff <= div_busy_in;
         r_ff        <= r_in;
         c_ff        <= c_in;
         slot_ff     <= slot_in;
         rd_vld_ff   <= rd_en;
         if (cfg_wr) begin
            unique case (cfg_idx)
               REG_PLANE_ROWS:  plane_rows_ff  <= csr_pwdata[11:0];
               REG_PLANE_COLS:  plane_cols_ff  <= csr_pwdata[8:0];
               REG_POOL_ROWS:   pool_rows_ff   <= csr_pwdata[3:0];
               REG_POOL_COLS:   pool_cols_ff   <= csr_pwdata[3:0];
               REG_STEP_ROWS:   step_rows_ff   <= csr_pwdata[3:0];
               REG_STEP_COLS:   step_cols_ff   <= csr_pwdata[3:0];
               REG_BORDER_ROWS: border_rows_ff <= csr_pwdata[2:0];
               REG_BORDER_COLS: border_cols_ff <= csr_pwdata[2:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      div_cnt_ff <= div_cnt_in;
      dq_ff      <= dq_in;
      dr_ff      <= dr_in;
      oh_ff      <= oh_in;
      ow_ff      <= ow_in;
      ra_lo_ff   <= ra_lo_in;
      ca_lo_ff   <= ca_lo_in;
      rt_ff <= rt_in;  rm_ff <= rm_in;  rq_ff <= rq_in;
      ct_ff <= ct_in;  cm_ff <= cm_in;  cq_ff <= cq_in;
      ra_ff <= ra_in;  rz_ff <= rz_in;  ca_ff <= ca_in;  cz_ff <= cz_in;
      orow_ff  <= orow_in;
      ocol_ff  <= ocol_in;
      y_ff     <= y_in;
      y_end_ff <= y_end_in;
      x_ff     <= x_in;
      x0_ff    <= x0_in;
      x_end_ff <= x_end_in;
      best_ff  <= best_in;
   end

   always_ff @(posedge clock) begin
      if (req_acc) mem[wr_addr] <= req_tdata[SAMPLE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   a_busy_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input taken while result pending");

   a_scan_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (y_ff <= y_end_ff && x_ff <= x_end_ff))
      else $error("window scan out of bounds");

   a_plane_end_is_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_tuser) |-> rsp_tlast)
      else $error("plane end not at end of run");

   a_accept_to_range: assert property (@(posedge clock) disable iff (reset)
      (req_acc && !cfg_wr) |=> (state_ff == ST_RANGE))
      else $error("accepted sample not processed");

endmodule
